### hdl/udp_port_demux_table_core_assert.svh
// ----------------------------------------------------------------------------
// UDP port demultiplexer assertion macros
// Shared concurrent assertion forms for the slot table core.
// ----------------------------------------------------------------------------
`ifndef UDP_PORT_DEMUX_TABLE_CORE_ASSERT_SVH
`define UDP_PORT_DEMUX_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("udp port demux table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("udp port demux table: next-cycle check failed");

`endif

### hdl/udp_pdt_pkg.sv
// ----------------------------------------------------------------------------
// UDP port demultiplexer package
// Request and status codes, slot entry layout and shared control types.
// ----------------------------------------------------------------------------
package udp_pdt_pkg;

    localparam logic [2:0] REQ_FIND_FREE   = 3'd0;
    localparam logic [2:0] REQ_BIND        = 3'd1;
    localparam logic [2:0] REQ_SET_HANDLER = 3'd2;
    localparam logic [2:0] REQ_FREE        = 3'd3;
    localparam logic [2:0] REQ_DELIVER     = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_USE    = 3'd1;
    localparam logic [2:0] ST_NOT_BOUND = 3'd2;
    localparam logic [2:0] ST_NO_FREE   = 3'd3;
    localparam logic [2:0] ST_NO_MATCH  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  handler;
    } t_entry;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  slot;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
        logic [7:0]  handler_id;
    } t_request;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] found_slot;
        logic [7:0] matched_handler;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bound;
    } t_mem_ctl;

endpackage

### hdl/udp_port_demux_table_core.sv
// ----------------------------------------------------------------------------
// UDP port demultiplexer slot table
// Find free, bind, set handler, free and deliver lookup requests over a table
// of TABLE_SLOTS endpoint slots held in a one-port-read, one-port-write memory.
// Find free, bind and deliver scan the table one slot per memory read; set
// handler reads only its named slot, while free and requests rejected up front
// skip the scan. One request is in work at a time.
// Reset clears every slot at once through the per-slot bound flags.
// ----------------------------------------------------------------------------
`include "udp_port_demux_table_core_assert.svh"

module udp_port_demux_table_core #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: slot[2:0], ip_addr[34:3], port_num[50:35], handler_id[58:51], zero fill
    input  logic [63:0] s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[2:0], found_slot[5:3], matched_handler[13:6], zero fill
    output logic [15:0] m_axis_tdata
);
    import udp_pdt_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    t_request      w_req;
    t_result       w_res;
    logic          w_res_valid;
    logic          w_res_ready;
    t_mem_ctl      w_mem_ctl;
    logic [IW-1:0] w_rd_idx;
    logic [IW-1:0] w_wr_idx;
    t_entry        w_wr_data;
    t_entry        w_rd_data;
    logic          w_rd_bound;

    t_result       r_out;
    logic          r_out_valid;

    assign w_req.req_type   = s_axis_tuser;
    assign w_req.slot       = s_axis_tdata[2:0];
    assign w_req.ip_addr    = s_axis_tdata[34:3];
    assign w_req.port_num   = s_axis_tdata[50:35];
    assign w_req.handler_id = s_axis_tdata[58:51];

    udp_pdt_ctrl #(
        .SLOTS(TABLE_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_ctl   (w_mem_ctl),
        .o_rd_idx    (w_rd_idx),
        .o_wr_idx    (w_wr_idx),
        .o_wr_data   (w_wr_data),
        .i_rd_bound  (w_rd_bound),
        .i_rd_data   (w_rd_data)
    );

    udp_pdt_mem #(
        .SLOTS(TABLE_SLOTS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mem_ctl),
        .i_rd_idx   (w_rd_idx),
        .i_wr_idx   (w_wr_idx),
        .i_wr_data  (w_wr_data),
        .o_rd_bound (w_rd_bound),
        .o_rd_data  (w_rd_data)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.matched_handler, r_out.found_slot, r_out.status};

    `UPDT_ASSERT_NEXT(a_one_request_at_a_time, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `UPDT_ASSERT_NEXT(a_result_held_while_stalled, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `UPDT_ASSERT_IMPL(a_failed_status_has_no_slot, i_clk, i_rst_n,
        r_out_valid && (r_out.status != ST_OK),
        (r_out.found_slot == 3'd0) && (r_out.matched_handler == 8'd0))

endmodule

### hdl/udp_pdt_mem.sv
// ----------------------------------------------------------------------------
// UDP port demultiplexer slot memory
// Synchronous slot store with registered read data and per-slot bound flags.
// ----------------------------------------------------------------------------
module udp_pdt_mem #(
    parameter int SLOTS = 8,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  udp_pdt_pkg::t_mem_ctl i_ctl,
    input  logic [IW-1:0]        i_rd_idx,
    input  logic [IW-1:0]        i_wr_idx,
    input  udp_pdt_pkg::t_entry  i_wr_data,
    output logic                 o_rd_bound,
    output udp_pdt_pkg::t_entry  o_rd_data
);
    import udp_pdt_pkg::*;

    t_entry           r_mem [SLOTS];
    t_entry           r_rd_data;
    logic [SLOTS-1:0] r_bound;
    logic             r_rd_bound;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound    <= '0;
            r_rd_bound <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_bound[i_wr_idx] <= i_ctl.wr_bound;
            end
            if (i_ctl.rd_en) begin
                r_rd_bound <= r_bound[i_rd_idx];
            end
        end
    end

    assign o_rd_bound = r_rd_bound;
    assign o_rd_data  = r_rd_data;

endmodule

### hdl/udp_pdt_ctrl.sv
// ----------------------------------------------------------------------------
// UDP port demultiplexer request sequencer
// Scans one entry per cycle; bind, set handler and free may write one slot.
// ----------------------------------------------------------------------------
module udp_pdt_ctrl #(
    parameter int SLOTS = 8,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  udp_pdt_pkg::t_request i_req,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output udp_pdt_pkg::t_result  o_res,
    output udp_pdt_pkg::t_mem_ctl o_mem_ctl,
    output logic [IW-1:0]         o_rd_idx,
    output logic [IW-1:0]         o_wr_idx,
    output udp_pdt_pkg::t_entry   o_wr_data,
    input  logic                  i_rd_bound,
    input  udp_pdt_pkg::t_entry   i_rd_data
);
    import udp_pdt_pkg::*;

    localparam logic [8:0]    SLOTS_W  = 9'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state   r_state, n_state;
    t_request r_req, n_req;
    t_result  r_res, n_res;
    t_entry   r_wdata, n_wdata;
    logic     r_wbound, n_wbound;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_end, n_end;
    logic [IW-1:0] r_slot_idx, n_slot_idx;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic     r_issuing, n_issuing;
    logic     r_chk, n_chk;
    logic     r_chk_last, n_chk_last;

    logic [8:0] in_slot_ext;
    logic       in_slot_ok;
    logic [8:0] chk_idx_ext;
    logic       pair_match;
    logic       hit;
    logic       scan_stop;

    assign in_slot_ext = {6'b0, i_req.slot};
    assign in_slot_ok  = in_slot_ext < SLOTS_W;
    assign chk_idx_ext = 9'(r_chk_idx);
    assign pair_match  = (i_rd_data.addr == r_req.ip_addr) &&
                         (i_rd_data.port == r_req.port_num);

    always_comb begin
        case (r_req.req_type)
            REQ_FIND_FREE:   hit = !i_rd_bound;
            REQ_BIND:        hit = (r_chk_idx != r_slot_idx) && i_rd_bound && pair_match;
            REQ_SET_HANDLER: hit = i_rd_bound;
            REQ_DELIVER:     hit = i_rd_bound && (i_rd_data.handler != 8'd0) && pair_match;
            default:         hit = 1'b0;
        endcase
    end

    assign scan_stop = r_chk && (hit || r_chk_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.req_type)
                        REQ_FIND_FREE, REQ_DELIVER: n_state = S_SCAN;
                        REQ_BIND, REQ_SET_HANDLER:  n_state = in_slot_ok ? S_SCAN : S_DONE;
                        REQ_FREE:                   n_state = in_slot_ok ? S_WRITE : S_DONE;
                        default:                    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    if (((r_req.req_type == REQ_BIND) && !hit) ||
                        ((r_req.req_type == REQ_SET_HANDLER) && hit)) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready        = (r_state == S_IDLE);
        o_res_valid        = (r_state == S_DONE);
        o_mem_ctl.rd_en    = (r_state == S_SCAN) && r_issuing;
        o_mem_ctl.wr_en    = (r_state == S_WRITE);
        o_mem_ctl.wr_bound = r_wbound;
        o_rd_idx           = r_idx;
        o_wr_idx           = r_slot_idx;
        o_wr_data          = r_wdata;
        o_res              = r_res;
    end

    always_comb begin
        n_req      = r_req;
        n_res      = r_res;
        n_wdata    = r_wdata;
        n_wbound   = r_wbound;
        n_idx      = r_idx;
        n_end      = r_end;
        n_slot_idx = r_slot_idx;
        n_issuing  = r_issuing;
        n_chk      = (r_state == S_SCAN) && r_issuing;
        n_chk_idx  = r_idx;
        n_chk_last = (r_idx == r_end);

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req                 = i_req;
                    n_slot_idx            = in_slot_ext[IW-1:0];
                    n_issuing             = 1'b1;
                    n_res.found_slot      = 3'd0;
                    n_res.matched_handler = 8'd0;
                    n_wbound              = (i_req.req_type != REQ_FREE);
                    n_wdata               = '0;
                    n_idx                 = '0;
                    n_end                 = LAST_IDX;
                    case (i_req.req_type)
                        REQ_FIND_FREE: n_res.status = ST_NO_FREE;
                        REQ_BIND: begin
                            n_res.status = in_slot_ok ? ST_OK : ST_NOT_BOUND;
                            n_wdata.addr = i_req.ip_addr;
                            n_wdata.port = i_req.port_num;
                        end
                        REQ_SET_HANDLER: begin
                            n_res.status = ST_NOT_BOUND;
                            n_idx        = in_slot_ext[IW-1:0];
                            n_end        = in_slot_ext[IW-1:0];
                        end
                        REQ_FREE: n_res.status = in_slot_ok ? ST_OK : ST_NOT_BOUND;
                        default:  n_res.status = ST_NO_MATCH;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    if (r_idx == r_end) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_chk && (r_req.req_type == REQ_BIND) && (r_chk_idx == r_slot_idx)) begin
                    n_wdata.handler = i_rd_bound ? i_rd_data.handler : 8'd0;
                end
                if (scan_stop) begin
                    n_issuing = 1'b0;
                    if (hit) begin
                        case (r_req.req_type)
                            REQ_FIND_FREE: begin
                                n_res.status     = ST_OK;
                                n_res.found_slot = chk_idx_ext[2:0];
                            end
                            REQ_BIND: n_res.status = ST_IN_USE;
                            REQ_SET_HANDLER: begin
                                n_res.status    = ST_OK;
                                n_wdata.addr    = i_rd_data.addr;
                                n_wdata.port    = i_rd_data.port;
                                n_wdata.handler = r_req.handler_id;
                            end
                            REQ_DELIVER: begin
                                n_res.status          = ST_OK;
                                n_res.found_slot      = chk_idx_ext[2:0];
                                n_res.matched_handler = i_rd_data.handler;
                            end
                            default: n_res.status = ST_NO_MATCH;
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issuing  <= 1'b0;
            r_chk      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issuing  <= n_issuing;
            r_chk      <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_wdata    <= n_wdata;
        r_wbound   <= n_wbound;
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_slot_idx <= n_slot_idx;
        r_chk_idx  <= n_chk_idx;
        r_chk_last <= n_chk_last;
    end

endmodule

### verif/tb_udp_port_demux_table_core.sv
// ----------------------------------------------------------------------------
// Testbench for the UDP port demultiplexer slot table
// Drives find free, bind, set handler, free, deliver and reserved requests
// into the core with random gaps and stalls on both streams. It predicts each
// response from its own copy of the slot table and compares it field by field.
// ----------------------------------------------------------------------------
module tb_udp_port_demux_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import udp_pdt_pkg::*;

    localparam int          SLOTS          = 8;
    localparam logic [2:0]  REQ_RESERVED_LO = 3'd5;
    localparam logic [2:0]  REQ_RESERVED_HI = 3'd7;
    localparam int          RANDOM_ITEMS   = 1420;
    localparam int          IDLE_LIMIT     = 1000;
    localparam int          LONG_HOLD      = 200;
    localparam int          HOLD_AT_COUNT  = 400;
    localparam int          PAUSE_AT_ITEM  = 700;
    localparam int          BURST_FIRST    = 900;
    localparam int          BURST_LAST     = 1060;
    localparam int          PAIR_POOL      = 6;

    class port_table_scoreboard;
        logic [31:0] slot_addr[SLOTS];
        logic [15:0] slot_port[SLOTS];
        logic        slot_bound[SLOTS];
        logic [7:0]  slot_handler[SLOTS];
        t_result     responses_due[$];
        int          mismatch_count;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                clear_slot(s);
            end
            mismatch_count = 0;
        endfunction

        function void clear_slot(int s);
            slot_addr[s]    = '0;
            slot_port[s]    = '0;
            slot_bound[s]   = 1'b0;
            slot_handler[s] = '0;
        endfunction

        function t_result predict_response(t_request r);
            t_result res;
            logic    hit;
            int      idx;
            res = '{status: ST_NO_MATCH, found_slot: 3'd0, matched_handler: 8'd0};
            hit = 1'b0;
            idx = int'(r.slot);
            case (r.req_type)
                REQ_FIND_FREE: begin
                    res.status = ST_NO_FREE;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (!hit && !slot_bound[s]) begin
                            hit            = 1'b1;
                            res.status     = ST_OK;
                            res.found_slot = 3'(s);
                        end
                    end
                end
                REQ_BIND: begin
                    res.status = ST_OK;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (s != idx && slot_bound[s] && slot_addr[s] == r.ip_addr
                                && slot_port[s] == r.port_num) begin
                            res.status = ST_IN_USE;
                        end
                    end
                    if (res.status == ST_OK) begin
                        slot_addr[idx]  = r.ip_addr;
                        slot_port[idx]  = r.port_num;
                        slot_bound[idx] = 1'b1;
                    end
                end
                REQ_SET_HANDLER: begin
                    if (slot_bound[idx]) begin
                        slot_handler[idx] = r.handler_id;
                        res.status        = ST_OK;
                    end else begin
                        res.status = ST_NOT_BOUND;
                    end
                end
                REQ_FREE: begin
                    clear_slot(idx);
                    res.status = ST_OK;
                end
                REQ_DELIVER: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (!hit && slot_bound[s] && slot_handler[s] != 8'd0
                                && slot_addr[s] == r.ip_addr
                                && slot_port[s] == r.port_num) begin
                            hit                 = 1'b1;
                            res.status          = ST_OK;
                            res.found_slot      = 3'(s);
                            res.matched_handler = slot_handler[s];
                        end
                    end
                end
                default: begin
                    res.status = ST_NO_MATCH;
                end
            endcase
            return res;
        endfunction

        function void note_request(t_request r);
            responses_due.push_back(predict_response(r));
        endfunction

        function void check_response(logic [15:0] word);
            t_result want;
            t_result got;
            got.status          = word[2:0];
            got.found_slot      = word[5:3];
            got.matched_handler = word[13:6];
            if (responses_due.size() == 0) begin
                $error("response with no request outstanding: %h", word);
                mismatch_count++;
                return;
            end
            want = responses_due.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.found_slot !== want.found_slot) begin
                $error("found_slot: expected %0d, got %0d", want.found_slot, got.found_slot);
                mismatch_count++;
            end
            if (got.matched_handler !== want.matched_handler) begin
                $error("matched_handler: expected %0d, got %0d",
                       want.matched_handler, got.matched_handler);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return responses_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: slot[2:0], ip_addr[34:3], port_num[50:35], handler_id[58:51], zero fill
    logic [63:0] s_axis_tdata;
    // tuser: req_type[2:0]
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: status[2:0], found_slot[5:3], matched_handler[13:6], zero fill
    logic [15:0] m_axis_tdata;

    port_table_scoreboard board;
    bit          no_idle;
    int          responses_seen;
    logic [31:0] pool_addr[PAIR_POOL];
    logic [15:0] pool_port[PAIR_POOL];

    udp_port_demux_table_core #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_request(input logic [2:0] kind, input logic [2:0] slot,
                                input logic [31:0] addr, input logic [15:0] port,
                                input logic [7:0] hid);
        t_request r;
        int       gap;
        r   = '{req_type: kind, slot: slot, ip_addr: addr, port_num: port, handler_id: hid};
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, hid, port, addr, slot};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic wait_for_drain();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int          roll;
        int          pick;
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  hid;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, PAIR_POOL - 1);
        if ($urandom_range(0, 19) == 0) begin
            pool_addr[pick] = $urandom;
            pool_port[pick] = 16'($urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
            addr = pool_addr[pick];
            port = pool_port[pick];
        end else begin
            addr = $urandom;
            port = 16'($urandom);
        end
        hid = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        if (roll < 10) begin
            kind = REQ_FIND_FREE;
        end else if (roll < 35) begin
            kind = REQ_BIND;
        end else if (roll < 55) begin
            kind = REQ_SET_HANDLER;
        end else if (roll < 67) begin
            kind = REQ_FREE;
        end else if (roll < 97) begin
            kind = REQ_DELIVER;
        end else begin
            kind = 3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
        end
        send_request(kind, 3'($urandom_range(0, SLOTS - 1)), addr, port, hid);
    endtask

    initial begin : stimulus
        logic [31:0] a0;
        logic [15:0] p0;
        board          = new();
        no_idle        = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_FIND_FREE;
        for (int k = 0; k < PAIR_POOL; k++) begin
            pool_addr[k] = $urandom;
            pool_port[k] = 16'($urandom);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        a0 = $urandom;
        p0 = 16'($urandom);
        send_request(REQ_FIND_FREE, 3'd5, a0, p0, 8'd0);
        send_request(REQ_DELIVER, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_SET_HANDLER, 3'd3, a0, p0, 8'd9);
        send_request(REQ_BIND, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_BIND, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_request(REQ_BIND, 3'd1, 32'd0, 16'd0, 8'd0);
        send_request(REQ_BIND, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_SET_HANDLER, 3'd0, 32'd0, 16'd0, 8'hFF);
        send_request(REQ_SET_HANDLER, 3'd7, 32'd0, 16'd0, 8'd1);
        send_request(REQ_DELIVER, 3'd4, 32'd0, 16'd0, 8'd0);
        send_request(REQ_DELIVER, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'd0);
        for (int s = 1; s < SLOTS - 1; s++) begin
            send_request(REQ_BIND, 3'(s), a0 + 32'(s), p0 ^ 16'(s), 8'd0);
        end
        send_request(REQ_FIND_FREE, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_DELIVER, 3'd0, a0 + 32'd3, p0 ^ 16'd3, 8'd0);
        send_request(REQ_SET_HANDLER, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_DELIVER, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_FREE, 3'd7, 32'd0, 16'd0, 8'd0);
        send_request(REQ_FREE, 3'd7, 32'd0, 16'd0, 8'd0);
        send_request(REQ_FIND_FREE, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_RESERVED_LO, 3'd2, 32'd0, 16'd0, 8'd0);
        send_request(REQ_RESERVED_LO + 3'd1, 3'd0, 32'd0, 16'd0, 8'd0);
        send_request(REQ_RESERVED_HI, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= BURST_FIRST && n < BURST_LAST);
            if (n == PAUSE_AT_ITEM) begin
                s_axis_tvalid <= 1'b0;
                wait_for_drain();
            end
            send_random_request();
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait_for_drain();
        repeat (3 * SLOTS) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("** udp_port_demux_table_core: PASSED **");
        end else begin
            $display("** udp_port_demux_table_core: FAILED **");
        end
        $finish;
    end

    initial begin : response_sink
        int  wait_cycles;
        bit  held;
        held           = 1'b0;
        responses_seen = 0;
        m_axis_tready <= 1'b0;
        forever begin
            if (!held && responses_seen >= HOLD_AT_COUNT) begin
                held        = 1'b1;
                wait_cycles = LONG_HOLD;
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            board.check_response(m_axis_tdata);
            responses_seen++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** udp_port_demux_table_core: FAILED **");
                $finish;
            end
        end
    end

endmodule
